// ===== design/stc_pkg.sv =====
// Shared types and constants for the space-to-tab compressor.
// Holds character codes, the controller/datapath command and status structs.
// No dependencies.
package stc_pkg;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    // Widths of the column and pending-blank counters
    localparam int COL_W  = 7;
    localparam int PEND_W = 6;
    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};

    // Stop mask: bit k marks column k+1
    localparam int MASK_W = 64;
    localparam logic [MASK_W-1:0] MASK_RESET = 64'h8080_8080_8080_8080;

    // Output byte select
    localparam logic [1:0] SEL_TAB   = 2'd0;
    localparam logic [1:0] SEL_SPACE = 2'd1;
    localparam logic [1:0] SEL_CHAR  = 2'd2;

    // Pending-blank counter operations
    localparam logic [1:0] PEND_HOLD = 2'd0;
    localparam logic [1:0] PEND_INC  = 2'd1;
    localparam logic [1:0] PEND_DEC  = 2'd2;
    localparam logic [1:0] PEND_CLR  = 2'd3;

    // Column counter operations
    localparam logic [1:0] COL_HOLD = 2'd0;
    localparam logic [1:0] COL_NEXT = 2'd1;
    localparam logic [1:0] COL_INC  = 2'd2;
    localparam logic [1:0] COL_ONE  = 2'd3;

    typedef struct packed {
        logic       ld_char;
        logic       emit;
        logic [1:0] sel;
        logic       last;
        logic [1:0] pend_op;
        logic [1:0] col_op;
    } cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_tab;
        logic is_newline;
        logic stop;
        logic pend_zero;
        logic pend_one;
        logic pend_full;
        logic out_free;
    } status_t;

endpackage

// ===== design/stc_ctrl.sv =====
// Controller state machine for the space-to-tab compressor.
// Depends on stc_pkg; drives commands to stc_datapath from its status.
module stc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  stc_pkg::status_t st,
    output stc_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_FLUSH  = 2'd2;
    localparam logic [1:0] S_SEEK   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide the next step and the datapath command
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.sel       = stc_pkg::SEL_CHAR;
        cmd.pend_op   = stc_pkg::PEND_HOLD;
        cmd.col_op    = stc_pkg::COL_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.ld_char = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.is_space)
                begin
                    if (st.stop || st.pend_full)
                    begin
                        // Emit a tab on a stop, or a space when the count is full
                        if (st.out_free)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.last    = 1'b1;
                            cmd.sel     = st.stop ? stc_pkg::SEL_TAB : stc_pkg::SEL_SPACE;
                            cmd.pend_op = st.stop ? stc_pkg::PEND_CLR : stc_pkg::PEND_HOLD;
                            cmd.col_op  = stc_pkg::COL_NEXT;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        // Hold the blank back
                        cmd.pend_op = stc_pkg::PEND_INC;
                        cmd.col_op  = stc_pkg::COL_NEXT;
                        state_next  = S_IDLE;
                    end
                end
                else if (st.is_tab)
                begin
                    if (st.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.last    = 1'b1;
                        cmd.sel     = stc_pkg::SEL_TAB;
                        cmd.pend_op = stc_pkg::PEND_CLR;
                        if (st.stop)
                        begin
                            cmd.col_op = stc_pkg::COL_NEXT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.col_op = stc_pkg::COL_INC;
                            state_next = S_SEEK;
                        end
                    end
                end
                else if (!st.pend_zero)
                begin
                    state_next = S_FLUSH;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.sel    = stc_pkg::SEL_CHAR;
                    cmd.col_op = st.is_newline ? stc_pkg::COL_ONE : stc_pkg::COL_NEXT;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                // Drain pending blanks one per cycle while the output is free, then pass the character
                if (st.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = stc_pkg::SEL_SPACE;
                    cmd.pend_op = stc_pkg::PEND_DEC;
                    if (st.pend_one)
                    begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_SEEK:
            begin
                // Advance the column one step until a stop is reached
                if (st.stop)
                begin
                    cmd.col_op = stc_pkg::COL_NEXT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.col_op = stc_pkg::COL_INC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/stc_datapath.sv =====
// Datapath for the space-to-tab compressor: character, column, pending count,
// stop mask and output register. Depends on stc_pkg; driven by stc_ctrl.
module stc_datapath
#(
    parameter int LINE_LIMIT = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [stc_pkg::MASK_W-1:0]   cfg_wdata,
    input  logic [7:0]                   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,
    output logic                         m_axis_tlast,
    input  stc_pkg::cmd_t                cmd,
    output stc_pkg::status_t             st
);

    localparam logic [stc_pkg::COL_W-1:0] LIMIT_C = stc_pkg::COL_W'(LINE_LIMIT);
    localparam logic [stc_pkg::COL_W-1:0] PAST_C  = stc_pkg::COL_W'(LINE_LIMIT + 1);

    logic [stc_pkg::MASK_W-1:0] mask_reg;
    logic [7:0]                 char_reg;
    logic [stc_pkg::COL_W-1:0]  col_reg;
    logic [stc_pkg::COL_W-1:0]  col_next;
    logic [stc_pkg::COL_W-1:0]  col_adv;
    logic [stc_pkg::COL_W-1:0]  col_idx;
    logic [stc_pkg::PEND_W-1:0] pend_reg;
    logic [stc_pkg::PEND_W-1:0] pend_next;
    logic                       out_valid_reg;
    logic [7:0]                 out_char_reg;
    logic                       out_last_reg;
    logic [7:0]                 emit_char;

    // Write the stop mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= stc_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            mask_reg <= cfg_wdata;
        end
    end

    // Capture the requested character
    always_ff @(posedge clk)
    begin
        if (cmd.ld_char)
        begin
            char_reg <= s_axis_tdata;
        end
    end

    // Stop test: past the limit every column is a stop
    assign col_idx = col_reg - stc_pkg::COL_W'(1);
    assign col_adv = (col_reg > LIMIT_C) ? PAST_C : col_reg + stc_pkg::COL_W'(1);

    always_comb
    begin
        case (cmd.col_op)
            stc_pkg::COL_NEXT: col_next = col_adv;
            stc_pkg::COL_INC:  col_next = col_reg + stc_pkg::COL_W'(1);
            stc_pkg::COL_ONE:  col_next = stc_pkg::COL_W'(1);
            default:           col_next = col_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.pend_op)
            stc_pkg::PEND_INC: pend_next = pend_reg + stc_pkg::PEND_W'(1);
            stc_pkg::PEND_DEC: pend_next = pend_reg - stc_pkg::PEND_W'(1);
            stc_pkg::PEND_CLR: pend_next = '0;
            default:           pend_next = pend_reg;
        endcase
    end

    // Advance column and pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= stc_pkg::COL_W'(1);
            pend_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            pend_reg <= pend_next;
        end
    end

    // Select the byte to emit
    always_comb
    begin
        case (cmd.sel)
            stc_pkg::SEL_TAB:   emit_char = stc_pkg::CH_TAB;
            stc_pkg::SEL_SPACE: emit_char = stc_pkg::CH_SPACE;
            default:            emit_char = char_reg;
        endcase
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= cmd.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // Report status to the controller
    always_comb
    begin
        st.is_space   = (char_reg == stc_pkg::CH_SPACE);
        st.is_tab     = (char_reg == stc_pkg::CH_TAB);
        st.is_newline = (char_reg == stc_pkg::CH_NEWLINE);
        st.stop       = (col_reg > LIMIT_C) || (col_reg == '0) ||
                        mask_reg[col_idx[5:0]];
        st.pend_zero  = (pend_reg == '0);
        st.pend_one   = (pend_reg == stc_pkg::PEND_W'(1));
        st.pend_full  = (pend_reg == stc_pkg::PEND_MAX);
        st.out_free   = !out_valid_reg || m_axis_tready;
    end

endmodule

// ===== design/space_to_tab_compressor_top.sv =====
// Space-to-tab compressor, top level.
// Channels: s_axis carries one character byte per request; m_axis carries
// the emitted bytes, with tlast on the final byte caused by each request.
// A request that only holds a blank back produces no output at all.
// cfg_we/cfg_wdata load the 64-bit stop mask (bit k = column k+1); write
// it only while the block is idle.
// Timing: a request is taken in IDLE and decoded in DECODE, which waits for a
// free output register when it has a byte to emit; the byte is loaded into
// the output register from DECODE and shows on m_axis once registered. Held
// blanks are flushed first in FLUSH, one per cycle while the output is free.
// A tab off a stop then walks the column counter in SEEK to the next stop.
// Only one request is in work at a time; a new request is accepted
// while the previous result still waits in the output register.
// Reset: column returns to 1, no blanks are pending, the stop mask returns
// to every eighth column and the output register empties.
// Stall: while m_axis_tready is low the output byte holds and the block
// waits before loading the next byte; requests that need no output pass.
// Depends on stc_pkg, stc_ctrl and stc_datapath.
module space_to_tab_compressor_top
#(
    parameter int LINE_LIMIT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,     // stop_mask
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_char
    output logic        m_axis_tlast   // last
);

    stc_pkg::cmd_t    cmd;
    stc_pkg::status_t st;

    stc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    stc_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .st            (st)
    );

endmodule

// ===== design/stc_checker.sv =====
// Port-level checks for the space-to-tab compressor.
// Depends on stc_pkg; bound to space_to_tab_compressor_top below.
module stc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // One request at a time: after a request the input side closes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // Only held blanks come out ahead of the final byte of a request
    a_early_bytes_are_spaces: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata == stc_pkg::CH_SPACE)
        else $error("non-final output byte is not a space");

    // A new output appears only after the input side was closed for decoding
    a_output_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("output appeared without a decode cycle");

    // Stalled output holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind space_to_tab_compressor_top stc_checker u_stc_checker (.*);

// ===== tb/stc_scoreboard.sv =====
// Scoreboard for the space-to-tab compressor: watches both stream channels and
// the stop-mask port, predicts the emitted bytes and compares them in order.
// Depends on stc_pkg for the character codes and counter widths.
module stc_scoreboard
#(
    parameter int LINE_LIMIT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          bytes_outstanding
);

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    out_byte_t                  bytes_due[$];
    logic [stc_pkg::MASK_W-1:0] stop_mask;
    logic [stc_pkg::COL_W-1:0]  column;
    logic [stc_pkg::PEND_W-1:0] held_blanks;

    // Count one mismatch and print one line for it
    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic on_stop(input logic [stc_pkg::COL_W-1:0] col);
        if (col > LINE_LIMIT || col == '0)
            return 1'b1;
        return stop_mask[col - stc_pkg::COL_W'(1)];
    endfunction

    function automatic logic [stc_pkg::COL_W-1:0] step_col(
        input logic [stc_pkg::COL_W-1:0] col);
        return (col > LINE_LIMIT) ? stc_pkg::COL_W'(LINE_LIMIT + 1)
                                  : col + stc_pkg::COL_W'(1);
    endfunction

    // Work out the bytes caused by one request and queue them
    task automatic compress_char(input logic [7:0] ch);
        logic [7:0] emitted[$];
        if (ch == stc_pkg::CH_SPACE)
        begin
            if (on_stop(column))
            begin
                held_blanks = '0;
                emitted.push_back(stc_pkg::CH_TAB);
            end
            else if (held_blanks == stc_pkg::PEND_MAX)
                emitted.push_back(stc_pkg::CH_SPACE);
            else
                held_blanks++;
            column = step_col(column);
        end
        else if (ch == stc_pkg::CH_TAB)
        begin
            held_blanks = '0;
            emitted.push_back(stc_pkg::CH_TAB);
            while (!on_stop(column))
                column++;
            column = step_col(column);
        end
        else
        begin
            while (held_blanks != '0)
            begin
                emitted.push_back(stc_pkg::CH_SPACE);
                held_blanks--;
            end
            emitted.push_back(ch);
            column = (ch == stc_pkg::CH_NEWLINE) ? stc_pkg::COL_W'(1) : step_col(column);
        end
        foreach (emitted[i])
            bytes_due.push_back('{ch: emitted[i], last: (i == emitted.size() - 1)});
    endtask

    // Follow both channels; the mask is only written while the block is idle
    always @(posedge clk or negedge rst_n)
    begin
        out_byte_t want;
        if (!rst_n)
        begin
            stop_mask   = stc_pkg::MASK_RESET;
            column      = stc_pkg::COL_W'(1);
            held_blanks = '0;
            bytes_due.delete();
            bytes_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                stop_mask = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                compress_char(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (bytes_due.size() == 0)
                    note_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                else
                begin
                    want = bytes_due.pop_front();
                    if (m_axis_tdata !== want.ch)
                        note_mismatch($sformatf("byte %02h, expected %02h",
                                                m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.last)
                        note_mismatch($sformatf("tlast %b on byte %02h, expected %b",
                                                m_axis_tlast, want.ch, want.last));
                end
            end
            bytes_outstanding <= bytes_due.size();
        end
    end

    initial mismatches = 0;

endmodule

// ===== tb/testbench.sv =====
// Top of the space-to-tab compressor testbench: drives character requests,
// stop-mask writes and output back-pressure, then gives the verdict.
// Depends on stc_pkg, space_to_tab_compressor_top and stc_scoreboard.
module testbench;

    localparam int LIMIT      = 64;
    localparam int SETTLE_CYC = 90;
    localparam int LONG_HOLD  = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int mismatches;
    int bytes_outstanding;

    bit send_gaps;
    bit recv_gaps;
    bit long_hold_req;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    space_to_tab_compressor_top #(.LINE_LIMIT(LIMIT)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    stc_scoreboard #(.LINE_LIMIT(LIMIT)) u_scoreboard (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .mismatches        (mismatches),
        .bytes_outstanding (bytes_outstanding)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_cycles();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Printable text most of the time, any byte at all otherwise
    function automatic logic [7:0] plain_char();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(33, 126));
    endfunction

    // Offer one request, idling first at random, and wait for it to be taken
    task automatic send_char(input logic [7:0] ch);
        int gap;
        if (send_gaps && $urandom_range(0, 99) < 30)
        begin
            gap = gap_cycles();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering, wait for every expected byte, then let a tab walk finish
    task automatic drain_block(input int settle);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic load_stop_mask(input logic [63:0] mask);
        drain_block(SETTLE_CYC);
        cfg_wdata <= mask;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random lines: words, runs of spaces, tabs and newlines
    task automatic send_text(input int n_items, input int newline_pct);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < newline_pct)
            begin
                send_char(stc_pkg::CH_NEWLINE);
                sent++;
            end
            else if (pick < newline_pct + 10)
            begin
                send_char(stc_pkg::CH_TAB);
                sent++;
            end
            else if (pick < newline_pct + 45)
            begin
                run = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                                    : $urandom_range(1, 10);
                repeat (run) send_char(stc_pkg::CH_SPACE);
                sent += run;
            end
            else
            begin
                run = $urandom_range(1, 6);
                repeat (run) send_char(plain_char());
                sent += run;
            end
        end
    endtask

    // Output back-pressure: random gaps, plus one long hold on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                gap_left = LONG_HOLD;
            end
            if (gap_left > 0)
            begin
                m_axis_tready <= 1'b0;
                gap_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (recv_gaps && $urandom_range(0, 99) < 25)
                    gap_left = gap_cycles();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        send_gaps     = 1'b0;
        recv_gaps     = 1'b0;
        long_hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset mask: stops at columns 8, 16, ...
        send_char("x");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(stc_pkg::CH_NEWLINE);
        repeat (7) send_char(stc_pkg::CH_SPACE);   // hold seven blanks
        send_char(stc_pkg::CH_TAB);                // tab on a stop drops them
        send_char(stc_pkg::CH_SPACE);
        send_char("z");                            // flush one blank, then the letter
        send_char(stc_pkg::CH_TAB);                // tab off a stop walks to the next
        repeat (7) send_char(stc_pkg::CH_SPACE);
        send_char(stc_pkg::CH_SPACE);              // space landing on a stop
        send_char(stc_pkg::CH_NEWLINE);

        // Random text on the reset mask, with idling on both sides
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_text(50, 8);

        // No stops in the mask: fill the blank store, then pass the limit
        load_stop_mask(64'h0);
        send_char(stc_pkg::CH_NEWLINE);
        repeat (64) send_char(stc_pkg::CH_SPACE);
        send_char("Q");                            // flush a full store of blanks
        send_text(35, 1);

        // Every column a stop; hold the output off while requests pile up
        load_stop_mask('1);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        long_hold_req = 1'b1;
        send_text(35, 5);

        // Random mask, then only the last column inside the limit
        load_stop_mask({$urandom(), $urandom()});
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_text(40, 6);
        load_stop_mask(64'h8000_0000_0000_0000);
        send_text(30, 3);

        drain_block(SETTLE_CYC);
        if (mismatches == 0 && bytes_outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Give up on a hang
    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
